[src/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [CFG_WIDTH-1:0] MIN_PULSE_RST  = CFG_WIDTH'(50);
  localparam logic [CFG_WIDTH-1:0] HOLD_PULSE_RST = CFG_WIDTH'(1000);

  typedef enum logic [0:0] {
    REG_MIN_PULSE  = 1'b0,
    REG_HOLD_PULSE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_UP      = 3'd1,
    ST_DOWN    = 3'd2,
    ST_HOLD    = 3'd3,
    ST_PRESSED = 3'd4,
    ST_LONG    = 3'd5
  } btn_state_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  last_time;
    logic [COUNT_WIDTH-1:0] press_cnt;
    logic [COUNT_WIDTH-1:0] release_cnt;
    logic [2:0]             mode;
  } bpc_state_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] min_pulse;
    logic [CFG_WIDTH-1:0] hold_pulse;
  } bpc_cfg_t;

endpackage

[src/bpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Configuration registers: minimum pulse and hold thresholds.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0] cfg_data_i,
  output bpc_pkg::bpc_cfg_t             cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse  <= MIN_PULSE_RST;
      cfg_q.hold_pulse <= HOLD_PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_PULSE:  cfg_q.min_pulse  <= cfg_data_i;
        REG_HOLD_PULSE: cfg_q.hold_pulse <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/bpc_next_state.sv]
// ----------------------------------------------------------------------------
// bpc_next_state
// One poll of the classifier state machine: one-shot clear, then a
// timestamp-gated step with saturating counters.
// ----------------------------------------------------------------------------
module bpc_next_state (
  input  bpc_pkg::bpc_state_t            cur_i,
  input  bpc_pkg::bpc_cfg_t              cfg_i,
  input  logic [bpc_pkg::TIME_WIDTH-1:0] time_now_i,
  input  logic                           button_level_i,
  output bpc_pkg::bpc_state_t            nxt_o
);
  import bpc_pkg::*;

  bpc_state_t             st;
  logic                   press;
  logic [COUNT_WIDTH-1:0] press_inc;
  logic [COUNT_WIDTH-1:0] release_inc;
  logic                   press_ge_min;
  logic                   press_ge_hold;
  logic                   release_ge_min;

  always_comb begin
    st    = cur_i;
    press = ~button_level_i;
    if (st.mode == ST_PRESSED || st.mode == ST_LONG) begin
      st.press_cnt   = '0;
      st.release_cnt = '0;
      st.mode        = ST_UP;
    end

    // compares use pre-increment counter values
    press_inc      = (&st.press_cnt) ? st.press_cnt : st.press_cnt + 1'b1;
    release_inc    = (&st.release_cnt) ? st.release_cnt : st.release_cnt + 1'b1;
    press_ge_min   = CMP_WIDTH'(st.press_cnt) >= CMP_WIDTH'(cfg_i.min_pulse);
    press_ge_hold  = CMP_WIDTH'(st.press_cnt) >= CMP_WIDTH'(cfg_i.hold_pulse);
    release_ge_min = CMP_WIDTH'(st.release_cnt) >= CMP_WIDTH'(cfg_i.min_pulse);

    if (time_now_i != st.last_time) begin
      st.last_time = time_now_i;
      case (st.mode)
        ST_UNKNOWN: begin
          st.press_cnt   = '0;
          st.release_cnt = '0;
          if (!press) st.mode = ST_UP;
        end
        ST_UP: begin
          if (press) begin
            st.press_cnt = press_inc;
            if (press_ge_min) st.mode = ST_DOWN;
          end else begin
            st.press_cnt = '0;
          end
        end
        ST_DOWN: begin
          if (press) begin
            st.release_cnt = '0;
            st.press_cnt   = press_inc;
            if (press_ge_hold) st.mode = ST_HOLD;
          end else begin
            st.release_cnt = release_inc;
            if (release_ge_min) st.mode = ST_PRESSED;
          end
        end
        ST_HOLD: begin
          if (press) begin
            st.release_cnt = '0;
          end else begin
            st.release_cnt = release_inc;
            if (release_ge_min) st.mode = ST_LONG;
          end
        end
        default: begin
          st.press_cnt   = '0;
          st.release_cnt = '0;
          st.mode        = ST_UNKNOWN;
        end
      endcase
    end
  end

  assign nxt_o = st;

endmodule

[src/button_press_classifier_unit.sv]
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Debounced push-button classifier, one poll per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one poll: a millisecond
//   timestamp and the raw active-low button level. Output channel
//   (out_valid_o/out_ready_i) returns exactly one item per poll: the state
//   code after that poll (unknown, up, down, hold, pressed, long pressed).
//   Path: an accepted poll enters the input register; the state update then
//   writes the result register and raises out_valid_o once that is free.
//   Throughput: one item per cycle while out_ready_i stays high; the state
//   update is one pass of compare and increment logic between the input
//   register and the state registers.
//   Reset: state unknown, counters and stored timestamp zero, min_pulse 50,
//   hold_pulse 1000. A poll with timestamp 0 right after reset does not act.
//   Stall: when out_ready_i is low the result holds, the input register
//   keeps one more item, and in_ready_o drops only when both are full.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   no item is in flight.
// ----------------------------------------------------------------------------
module button_press_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bpc_pkg::TIME_WIDTH-1:0] time_now_i,
  input  logic                           button_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     button_state_o
);
  import bpc_pkg::*;

  bpc_cfg_t              cfg;
  logic                  in_vld_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic                  level_q;
  logic                  out_vld_q;
  logic [2:0]            result_q;
  bpc_state_t            state_q;
  bpc_state_t            state_d;
  logic                  advance;
  logic                  load_in;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bpc_next_state u_next (
    .cur_i          (state_q),
    .cfg_i          (cfg),
    .time_now_i     (time_q),
    .button_level_i (level_q),
    .nxt_o          (state_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign load_in    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{last_time: '0, press_cnt: '0, release_cnt: '0, mode: ST_UNKNOWN};
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      time_q  <= time_now_i;
      level_q <= button_level_i;
    end
    if (advance) result_q <= state_d.mode;
  end

  assign out_valid_o    = out_vld_q;
  assign button_state_o = result_q;

endmodule

[src/bpc_checker.sv]
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the button press classifier, bound to the top.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] button_state_o
);
  import bpc_pkg::*;

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(button_state_o))
    else $error("result changed while stalled");

  // only defined state codes are reported
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> button_state_o <= 3'(ST_LONG))
    else $error("undefined state code");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // two register stages (input, result): no result right after reset
  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .button_state_o (button_state_o)
);
